// ===== rtl/rpsu_pkg.sv =====
package rpsu_pkg;

  localparam int NUM_PARAMS_DEF = 1024;
  localparam int IDX_W          = 10;
  localparam int QUEUE_DEPTH    = 4;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 32;

  localparam logic [1:0] SGN_ZERO = 2'd0;
  localparam logic [1:0] SGN_POS  = 2'd1;
  localparam logic [1:0] SGN_NEG  = 2'd3;

  localparam logic [13:0] ETA_MINUS_RST      = 14'd8192;
  localparam logic [15:0] ETA_PLUS_RST       = 16'd19661;
  localparam logic [30:0] MIN_STEP_RST       = 31'd1;
  localparam logic [30:0] MAX_STEP_RST       = 31'd3276800;
  localparam logic [30:0] INIT_STEP_RST      = 31'd6554;
  localparam logic [1:0]  UPDATE_METHOD_RST  = 2'd3;
  localparam logic [30:0] STEP_THRESHOLD_RST = 31'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ETA_MINUS      = 3'd0,
    REG_ETA_PLUS       = 3'd1,
    REG_MIN_STEP       = 3'd2,
    REG_MAX_STEP       = 3'd3,
    REG_INIT_STEP      = 3'd4,
    REG_UPDATE_METHOD  = 3'd5,
    REG_STEP_THRESHOLD = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    M_RPROP_PLUS   = 2'd0,
    M_RPROP_MINUS  = 2'd1,
    M_IRPROP_MINUS = 2'd2,
    M_IRPROP_PLUS  = 2'd3
  } method_t;

  typedef struct packed {
    logic [13:0] eta_minus;
    logic [15:0] eta_plus;
    logic [30:0] min_step_size;
    logic [30:0] max_step_size;
    logic [30:0] initial_step_size;
    logic [1:0]  update_method;
    logic [30:0] step_threshold;
  } cfg_t;

  typedef struct packed {
    logic             cmd;
    logic             in_range;
    logic [IDX_W-1:0] idx;
    logic [1:0]       sign;
    logic             err_up;
    logic             last;
  } item_t;

  typedef struct packed {
    logic [30:0] size;
    logic [31:0] step;
    logic [1:0]  sign;
  } entry_t;

  function automatic logic [31:0] neg_sat(input logic [31:0] v);
    return (v == 32'h8000_0000) ? 32'h7FFF_FFFF : (32'h0 - v);
  endfunction

endpackage

// ===== rtl/rpsu_grad_if.sv =====
interface rpsu_grad_if;
  logic                            valid;
  logic                            ready;
  logic                            cmd;
  logic [rpsu_pkg::IDX_W-1:0]      param_index;
  logic signed [31:0]              gradient;
  logic                            error_increased;
  logic                            last_in_sweep;

  modport source(output valid, cmd, param_index, gradient, error_increased, last_in_sweep,
                 input ready);
  modport sink(input valid, cmd, param_index, gradient, error_increased, last_in_sweep,
               output ready);
endinterface

// ===== rtl/rpsu_result_if.sv =====
interface rpsu_result_if;
  logic                       valid;
  logic                       ready;
  logic [rpsu_pkg::IDX_W-1:0] out_index;
  logic signed [31:0]         step;
  logic                       sweep_done;
  logic [30:0]                max_abs_step;
  logic                       step_converged;

  modport source(output valid, out_index, step, sweep_done, max_abs_step, step_converged,
                 input ready);
  modport sink(input valid, out_index, step, sweep_done, max_abs_step, step_converged,
               output ready);
endinterface

// ===== rtl/rpsu_cfg_if.sv =====
interface rpsu_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [rpsu_pkg::CFG_IDX_W-1:0]   index;
  logic [rpsu_pkg::CFG_DATA_W-1:0]  data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/rprop_step_update_unit.sv =====
// Channel  | Role   | Payload
// grad     | sink   | cmd, param_index, gradient, error_increased, last_in_sweep
// result   | source | out_index, step, sweep_done, max_abs_step, step_converged
// cfg      | sink   | index, data (register write, always ready)
//
// One item per cycle while result is not stalled; a gradient item that directly follows one
// for the same in-range index waits for its write-back, since the step size update is a
// read-modify-write of the parameter memory. From transfer to result an item passes the queue,
// the memory read with multiply into stage three, and clamp/select into the output register.
// Synchronous reset clears control and the sweep maximum and loads the configuration registers
// with their defaults; the parameter memory holds nothing until an entry is cleared or written.
// Result stalls back up through the queue to grad.ready.
module rprop_step_update_unit #(
  parameter int NUM_PARAMS = rpsu_pkg::NUM_PARAMS_DEF
) (
  input logic          clk,
  input logic          rst,
  rpsu_grad_if.sink    grad,
  rpsu_result_if.source result,
  rpsu_cfg_if.sink     cfg
);

  rpsu_pkg::cfg_t  cfg_q;
  logic            push_valid;
  logic            push_ready;
  rpsu_pkg::item_t push_item;
  logic            pop_valid;
  logic            pop_ready;
  rpsu_pkg::item_t pop_item;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.eta_minus         <= rpsu_pkg::ETA_MINUS_RST;
      cfg_q.eta_plus          <= rpsu_pkg::ETA_PLUS_RST;
      cfg_q.min_step_size     <= rpsu_pkg::MIN_STEP_RST;
      cfg_q.max_step_size     <= rpsu_pkg::MAX_STEP_RST;
      cfg_q.initial_step_size <= rpsu_pkg::INIT_STEP_RST;
      cfg_q.update_method     <= rpsu_pkg::UPDATE_METHOD_RST;
      cfg_q.step_threshold    <= rpsu_pkg::STEP_THRESHOLD_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (rpsu_pkg::cfg_reg_t'(cfg.index))
        rpsu_pkg::REG_ETA_MINUS:      cfg_q.eta_minus         <= cfg.data[13:0];
        rpsu_pkg::REG_ETA_PLUS:       cfg_q.eta_plus          <= cfg.data[15:0];
        rpsu_pkg::REG_MIN_STEP:       cfg_q.min_step_size     <= cfg.data[30:0];
        rpsu_pkg::REG_MAX_STEP:       cfg_q.max_step_size     <= cfg.data[30:0];
        rpsu_pkg::REG_INIT_STEP:      cfg_q.initial_step_size <= cfg.data[30:0];
        rpsu_pkg::REG_UPDATE_METHOD:  cfg_q.update_method     <= cfg.data[1:0];
        rpsu_pkg::REG_STEP_THRESHOLD: cfg_q.step_threshold    <= cfg.data[30:0];
        default: begin
        end
      endcase
    end
  end

  rpsu_front #(
    .NUM_PARAMS(NUM_PARAMS)
  ) u_front (
    .grad       (grad),
    .push_ready (push_ready),
    .push_valid (push_valid),
    .push_item  (push_item)
  );

  rpsu_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item),
    .pop_ready  (pop_ready)
  );

  rpsu_back #(
    .NUM_PARAMS(NUM_PARAMS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_q),
    .pop_valid (pop_valid),
    .pop_item  (pop_item),
    .pop_ready (pop_ready),
    .result    (result)
  );

`ifndef SYNTHESIS
  a_open_sweep_quiet: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.sweep_done |-> result.max_abs_step == '0 && !result.step_converged)
    else $error("sweep figures set on a result that does not close the sweep");

  a_out_of_range_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && (32'(result.out_index) >= NUM_PARAMS) |-> result.step == '0)
    else $error("nonzero step for an index beyond the parameter memory");

  a_step_saturated: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.step != 32'sh8000_0000)
    else $error("step reached the most negative value");

  a_method_write: assert property (@(posedge clk) disable iff (rst)
    cfg.valid && cfg.ready && cfg.index == rpsu_pkg::REG_UPDATE_METHOD
    |=> cfg_q.update_method == $past(cfg.data[1:0]))
    else $error("update method register missed a write");
`endif

endmodule

// ===== rtl/rpsu_front.sv =====
module rpsu_front #(
  parameter int NUM_PARAMS = rpsu_pkg::NUM_PARAMS_DEF
) (
  rpsu_grad_if.sink        grad,
  input  logic             push_ready,
  output logic             push_valid,
  output rpsu_pkg::item_t  push_item
);

  logic [1:0] sign;

  always_comb begin
    if (grad.gradient == '0) begin
      sign = rpsu_pkg::SGN_ZERO;
    end else if (grad.gradient[31]) begin
      sign = rpsu_pkg::SGN_NEG;
    end else begin
      sign = rpsu_pkg::SGN_POS;
    end
  end

  always_comb begin
    push_item.cmd      = grad.cmd;
    push_item.in_range = (32'(grad.param_index) < NUM_PARAMS);
    push_item.idx      = grad.param_index;
    push_item.sign     = sign;
    push_item.err_up   = grad.error_increased;
    push_item.last     = grad.last_in_sweep;
  end

  assign push_valid = grad.valid;
  assign grad.ready = push_ready;

endmodule

// ===== rtl/rpsu_queue.sv =====
module rpsu_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  input  rpsu_pkg::item_t  push_item,
  output logic             push_ready,
  output logic             pop_valid,
  output rpsu_pkg::item_t  pop_item,
  input  logic             pop_ready
);

  localparam int DEPTH = rpsu_pkg::QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);

  rpsu_pkg::item_t slots [DEPTH];
  logic [PW-1:0]   wptr;
  logic [PW-1:0]   rptr;
  logic [PW:0]     count;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (count != (PW+1)'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = slots[rptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= push_item;
    end
  end

endmodule

// ===== rtl/rpsu_back.sv =====
module rpsu_back #(
  parameter int NUM_PARAMS = rpsu_pkg::NUM_PARAMS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  rpsu_pkg::cfg_t   cfg,
  input  logic             pop_valid,
  input  rpsu_pkg::item_t  pop_item,
  output logic             pop_ready,
  rpsu_result_if.source    result
);

  localparam int AW = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;

  typedef struct packed {
    logic                       cmd;
    logic                       in_range;
    logic [rpsu_pkg::IDX_W-1:0] idx;
    logic [1:0]                 cur;
    logic                       err_up;
    logic                       last;
    logic                       same;
    logic                       flip;
    logic [30:0]                size;
    logic [31:0]                old_step;
    logic [46:0]                prod;
  } s3_t;

  rpsu_pkg::entry_t mem [NUM_PARAMS];
  rpsu_pkg::entry_t rdata;

  logic             s2_valid;
  rpsu_pkg::item_t  s2_item;
  logic             s3_valid;
  s3_t              s3;

  logic             byp_valid;
  logic [AW-1:0]    byp_addr;
  rpsu_pkg::entry_t byp_entry;

  logic             hazard;
  logic             s2_adv;
  logic             s3_adv;
  logic             pop;

  rpsu_pkg::entry_t cur_e;
  logic [AW-1:0]    s2_addr;
  logic             s2_both;
  logic             s2_same;
  logic             s2_flip;
  logic [15:0]      factor;
  logic [46:0]      prod;

  logic [47:0]      rnd;
  logic [31:0]      scaled;
  logic [30:0]      grow;
  logic [31:0]      shrink;
  logic [30:0]      size_n;
  logic [31:0]      sstep;
  logic [31:0]      apply_step;
  logic [1:0]       nsign;
  logic [31:0]      step_val;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  rpsu_pkg::entry_t wr_entry;
  logic [31:0]      neg_step;
  logic [30:0]      abs_step;
  logic [30:0]      run_max;
  logic [30:0]      sweep_max;

  assign s2_addr = AW'(s2_item.idx);
  assign hazard  = s2_valid && s2_item.in_range && !s2_item.cmd && s3_valid && s3.in_range &&
                   (s3.idx == s2_item.idx);
  assign s3_adv  = s3_valid && (!result.valid || result.ready);
  assign s2_adv  = s2_valid && !hazard && (!s3_valid || s3_adv);
  assign pop_ready = !s2_valid || s2_adv;
  assign pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (pop) begin
      rdata <= mem[AW'(pop_item.idx)];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byp_valid <= 1'b0;
    end else if (wr_en) begin
      byp_valid <= 1'b1;
    end
    if (wr_en) begin
      byp_addr  <= wr_addr;
      byp_entry <= wr_entry;
    end
  end

  always_comb begin
    cur_e   = (byp_valid && (byp_addr == s2_addr)) ? byp_entry : rdata;
    s2_both = (s2_item.sign != rpsu_pkg::SGN_ZERO) && (cur_e.sign != rpsu_pkg::SGN_ZERO);
    s2_same = s2_both && (s2_item.sign == cur_e.sign);
    s2_flip = s2_both && (s2_item.sign != cur_e.sign);
    factor  = s2_same ? cfg.eta_plus : {2'b00, cfg.eta_minus};
    prod    = {16'h0, cur_e.size} * {31'h0, factor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (pop) begin
        s2_valid <= 1'b1;
      end else if (s2_adv) begin
        s2_valid <= 1'b0;
      end
      if (s2_adv) begin
        s3_valid <= 1'b1;
      end else if (s3_adv) begin
        s3_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s2_item <= pop_item;
    end
    if (s2_adv) begin
      s3.cmd      <= s2_item.cmd;
      s3.in_range <= s2_item.in_range;
      s3.idx      <= s2_item.idx;
      s3.cur      <= s2_item.sign;
      s3.err_up   <= s2_item.err_up;
      s3.last     <= s2_item.last;
      s3.same     <= s2_same;
      s3.flip     <= s2_flip;
      s3.size     <= cur_e.size;
      s3.old_step <= cur_e.step;
      s3.prod     <= prod;
    end
  end

  always_comb begin
    rnd    = {1'b0, s3.prod} + 48'd8192;
    scaled = (rnd[47:46] != 2'b00) ? 32'hFFFF_FFFF : rnd[45:14];
    grow   = (scaled < {1'b0, cfg.max_step_size}) ? scaled[30:0] : cfg.max_step_size;
    shrink = (scaled > {1'b0, cfg.min_step_size}) ? scaled : {1'b0, cfg.min_step_size};
    if (s3.same) begin
      size_n = grow;
    end else if (s3.flip) begin
      size_n = shrink[30:0];
    end else begin
      size_n = s3.size;
    end

    case (s3.cur)
      rpsu_pkg::SGN_POS: sstep = 32'h0 - {1'b0, size_n};
      rpsu_pkg::SGN_NEG: sstep = {1'b0, size_n};
      default:           sstep = '0;
    endcase

    apply_step = sstep;
    nsign      = s3.cur;
    case (rpsu_pkg::method_t'(cfg.update_method))
      rpsu_pkg::M_RPROP_PLUS: begin
        if (s3.flip) begin
          apply_step = rpsu_pkg::neg_sat(s3.old_step);
          nsign      = rpsu_pkg::SGN_ZERO;
        end
      end
      rpsu_pkg::M_RPROP_MINUS: begin
        apply_step = sstep;
      end
      rpsu_pkg::M_IRPROP_MINUS: begin
        if (s3.flip) begin
          apply_step = '0;
          nsign      = rpsu_pkg::SGN_ZERO;
        end
      end
      rpsu_pkg::M_IRPROP_PLUS: begin
        if (s3.flip) begin
          apply_step = s3.err_up ? rpsu_pkg::neg_sat(s3.old_step) : '0;
          nsign      = rpsu_pkg::SGN_ZERO;
        end
      end
      default: begin
        apply_step = sstep;
      end
    endcase

    step_val = (s3.in_range && !s3.cmd) ? apply_step : '0;

    wr_en   = s3_adv && s3.in_range;
    wr_addr = AW'(s3.idx);
    if (s3.cmd) begin
      wr_entry.size = cfg.initial_step_size;
      wr_entry.step = '0;
      wr_entry.sign = rpsu_pkg::SGN_ZERO;
    end else begin
      wr_entry.size = size_n;
      wr_entry.step = apply_step;
      wr_entry.sign = nsign;
    end

    neg_step = rpsu_pkg::neg_sat(step_val);
    abs_step = step_val[31] ? neg_step[30:0] : step_val[30:0];
    run_max  = (abs_step > sweep_max) ? abs_step : sweep_max;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
      sweep_max    <= '0;
    end else begin
      if (s3_adv) begin
        result.valid <= 1'b1;
        sweep_max    <= s3.last ? '0 : run_max;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s3_adv) begin
      result.out_index      <= s3.idx;
      result.step           <= step_val;
      result.sweep_done     <= s3.last;
      result.max_abs_step   <= s3.last ? run_max : '0;
      result.step_converged <= s3.last && (run_max < cfg.step_threshold);
    end
  end

endmodule
